>>> rtl/assert_macros.svh
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/ilir_pkg.sv
// Package: types and constants of the indexed list
package ilir_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W = 2;
    localparam int POS_W  = 5;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Broadcast to every cell in the cycle of a transfer
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

>>> rtl/ilir_cell.sv
// One list entry: holds, takes its left or right neighbour, or loads the new word
module ilir_cell import ilir_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CW         = POS_W,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [CW-1:0]         i_pos,
    input  logic [DATA_WIDTH-1:0] i_val,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_tap
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_hit;

    assign w_hit = (i_pos == MY_IDX);

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (MY_IDX > i_pos) begin
                n_data = i_left;
            end else if (w_hit) begin
                n_data = i_val;
            end
        end else if (i_ctl.rem) begin
            if (MY_IDX >= i_pos) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = w_hit ? r_data : '0;

endmodule

>>> rtl/ilir_ctrl.sv
// Control: entry count, range checks, result register
`include "assert_macros.svh"

module ilir_ctrl import ilir_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CW         = POS_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [POS_W-1:0]      i_position,
    input  logic [DATA_WIDTH-1:0] i_rd_word,
    output t_cell_ctl             o_ctl,
    output logic [CW-1:0]         o_pos,
    output logic                  o_valid,
    output logic [WORD_W-1:0]     o_word_out,
    output logic [STAT_W-1:0]     o_status,
    output logic [LEN_W-1:0]      o_length
);

    localparam int FW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [FW-1:0]     r_fill,   n_fill;
    logic              r_valid;
    logic [WORD_W-1:0] r_word,   n_word;
    t_status           r_status, n_status;
    logic [LEN_W-1:0]  r_len;
    logic [CW-1:0]     w_pos;
    logic [CW-1:0]     w_fill;
    logic [WORD_W-1:0] w_rd32;

    assign w_pos  = CW'(i_position);
    assign w_fill = CW'(r_fill);

    generate
        if (DATA_WIDTH >= WORD_W) begin : g_trunc
            assign w_rd32 = i_rd_word[WORD_W-1:0];
        end else begin : g_ext
            assign w_rd32 = {{(WORD_W-DATA_WIDTH){1'b0}}, i_rd_word};
        end
    endgenerate

    always_comb begin
        o_ctl    = '0;
        n_fill   = r_fill;
        n_word   = '0;
        n_status = ST_OK;
        if (i_start) begin
            unique case (t_kind'(i_kind))
                KIND_INSERT: begin
                    if (w_pos > w_fill) begin
                        n_status = ST_RANGE;
                    end else if (w_fill == CAP_C) begin
                        n_status = ST_FULL;
                    end else begin
                        o_ctl.ins = 1'b1;
                        n_fill    = r_fill + 1'b1;
                    end
                end
                KIND_REMOVE: begin
                    if (w_pos >= w_fill) begin
                        n_status = ST_RANGE;
                    end else begin
                        o_ctl.rem = 1'b1;
                        n_word    = w_rd32;
                        n_fill    = r_fill - 1'b1;
                    end
                end
                KIND_READ: begin
                    if (w_pos >= w_fill) begin
                        n_status = ST_RANGE;
                    end else begin
                        n_word = w_rd32;
                    end
                end
                default: begin
                    n_status = ST_RANGE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_valid <= i_start;
        end
        r_word   <= n_word;
        r_status <= n_status;
        r_len    <= LEN_W'(n_fill);
    end

    assign o_pos      = w_pos;
    assign o_valid    = r_valid;
    assign o_word_out = r_word;
    assign o_status   = r_status;
    assign o_length   = r_len;

    `ASSERT_CLK(a_fill_cap, (w_fill <= CAP_C), "entry count above capacity")
    `ASSERT_CLK(a_one_result, i_start |=> r_valid, "transfer gave no result")
    `ASSERT_CLK(a_fill_hold, !i_start |=> $stable(r_fill), "count moved without a transfer")
    `ASSERT_CLK(a_full_len, r_valid && r_status == ST_FULL |-> w_fill == CAP_C, "bad full status")

endmodule

>>> rtl/indexed_list_insert_remove_top.sv
// Top level: indexed word list built as a row of shifting cells
//
// One operation (insert, remove or read at an index) is taken per clock:
// start is sampled at each edge and busy stays low, so an item may follow
// in the very next cycle. Its result appears on the o_ ports in the cycle
// after the transfer, marked by o_valid for exactly one cycle; the receiver
// cannot stall and must take it then. This follows from every cell at or
// past the index loading a neighbour's word or the new word in the same clock, and the read
// word being picked from all cells through one OR tree. Entry contents are
// not cleared at reset; only the count and o_valid are, so the list is usable at once.
module indexed_list_insert_remove_top import ilir_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [POS_W-1:0]  i_position,
    input  logic [WORD_W-1:0] i_value,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_word_out,
    output logic [STAT_W-1:0] o_status,
    output logic [LEN_W-1:0]  o_length
);

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = (FW > POS_W) ? FW : POS_W;

    t_cell_ctl             w_ctl;
    logic [CW-1:0]         w_pos;
    logic [DATA_WIDTH-1:0] w_val;
    logic [DATA_WIDTH-1:0] w_rd;
    logic [DATA_WIDTH-1:0] w_data [CAPACITY];
    logic [DATA_WIDTH-1:0] w_tap  [CAPACITY];
    logic                  w_start;

    // no wait states: every cycle can take a transfer
    assign busy    = 1'b0;
    assign w_start = start & ~busy;

    generate
        if (DATA_WIDTH <= WORD_W) begin : g_val_trunc
            assign w_val = i_value[DATA_WIDTH-1:0];
        end else begin : g_val_ext
            assign w_val = {{(DATA_WIDTH-WORD_W){1'b0}}, i_value};
        end
    endgenerate

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;
            // ends of the row: first cell never takes from the left,
            // last cell holds on removal
            if (g == 0) begin : g_first
                assign w_left = w_val;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = w_data[g];
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end
            ilir_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CW         (CW),
                .IDX        (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_pos   (w_pos),
                .i_val   (w_val),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_data[g]),
                .o_tap   (w_tap[g])
            );
        end
    endgenerate

    // only the addressed cell drives its tap
    always_comb begin
        w_rd = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd = w_rd | w_tap[k];
        end
    end

    ilir_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .CW         (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_kind     (i_kind),
        .i_position (i_position),
        .i_rd_word  (w_rd),
        .o_ctl      (w_ctl),
        .o_pos      (w_pos),
        .o_valid    (o_valid),
        .o_word_out (o_word_out),
        .o_status   (o_status),
        .o_length   (o_length)
    );

endmodule

>>> tb/indexed_list_insert_remove_top_tb.sv
// Testbench for the indexed list: directed and random operations, checked on every result
module indexed_list_insert_remove_top_tb import ilir_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CAPACITY       = CAPACITY_DEF;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_ITEMS   = 1020;
    localparam logic [1:0]  KIND_UNUSED    = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        t_status           status;
        logic [LEN_W-1:0]  length;
    } t_list_result;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              start      = 1'b0;
    logic [KIND_W-1:0] i_kind     = '0;
    logic [POS_W-1:0]  i_position = '0;
    logic [WORD_W-1:0] i_value    = '0;
    logic              busy;
    logic              o_valid;
    logic [WORD_W-1:0] o_word_out;
    logic [STAT_W-1:0] o_status;
    logic [LEN_W-1:0]  o_length;

    // Shadow copy of the list contents and count
    logic [WORD_W-1:0] list_words [CAPACITY];
    int                list_fill = 0;

    t_list_result      expected_results [$];
    int                error_count   = 0;
    int                ops_accepted  = 0;
    int                results_seen  = 0;
    int                ok_count      = 0;
    int                range_count   = 0;
    int                full_count    = 0;
    int                max_fill_seen = 0;
    int                idle_cycles   = 0;
    bit                sender_idles  = 1'b1;

    indexed_list_insert_remove_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_kind     (i_kind),
        .i_position (i_position),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_word_out (o_word_out),
        .o_status   (o_status),
        .o_length   (o_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one operation to the shadow list and returns the answer it gives
    function automatic t_list_result list_apply(logic [KIND_W-1:0] kind,
                                                logic [POS_W-1:0] pos,
                                                logic [WORD_W-1:0] value);
        t_list_result r;
        int           i;
        int           p;
        r.word   = '0;
        r.status = ST_OK;
        p        = int'(pos);
        case (kind)
            KIND_INSERT: begin
                if (p > list_fill) begin
                    r.status = ST_RANGE;
                end else if (list_fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_fill; i > p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p] = value;
                    list_fill++;
                end
            end
            KIND_REMOVE: begin
                if (p >= list_fill) begin
                    r.status = ST_RANGE;
                end else begin
                    r.word = list_words[p];
                    for (i = p; i + 1 < list_fill; i++)
                        list_words[i] = list_words[i+1];
                    list_fill--;
                end
            end
            KIND_READ: begin
                if (p >= list_fill)
                    r.status = ST_RANGE;
                else
                    r.word = list_words[p];
            end
            default: r.status = ST_RANGE;
        endcase
        r.length = LEN_W'(list_fill);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        $display("ERROR t=%0t %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Result checking, prediction on each transfer, and the watchdog
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        bit           progress;
        progress = 1'b0;
        if (i_rst_n) begin
            if (o_valid !== 1'b0) begin
                progress = 1'b1;
                got.word   = o_word_out;
                got.status = t_status'(o_status);
                got.length = o_length;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding", got.word, '0);
                end else begin
                    want = expected_results.pop_front();
                    results_seen++;
                    if (got.word !== want.word)
                        report_mismatch("word_out", got.word, want.word);
                    if (got.status !== want.status)
                        report_mismatch("status", WORD_W'(got.status), WORD_W'(want.status));
                    if (got.length !== want.length)
                        report_mismatch("length", WORD_W'(got.length), WORD_W'(want.length));
                    case (want.status)
                        ST_OK:    ok_count++;
                        ST_RANGE: range_count++;
                        default:  full_count++;
                    endcase
                end
            end
            if (start && busy === 1'b0) begin
                progress = 1'b1;
                expected_results.push_back(list_apply(i_kind, i_position, i_value));
                ops_accepted++;
                if (list_fill > max_fill_seen)
                    max_fill_seen = list_fill;
            end
        end
        if (progress)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("indexed_list_insert_remove_top: mismatch");
            $finish;
        end
    end

    // Sends one operation; returns at the edge where it was taken
    task automatic apply_op(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                            logic [WORD_W-1:0] value);
        int gap;
        gap = sender_idles ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_kind     <= kind;
        i_position <= pos;
        i_value    <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Holds off until every outstanding result has come back
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic test_empty_list();
        apply_op(KIND_READ, 5'd0, 32'h1234_5678);
        apply_op(KIND_REMOVE, 5'd0, '0);
        apply_op(KIND_INSERT, 5'd1, 32'hDEAD_BEEF);   // past the end of an empty list
        apply_op(KIND_UNUSED, 5'd31, 32'hFFFF_FFFF);
    endtask

    // Front, back and middle inserts up to capacity, then the full and out-of-range cases
    task automatic test_fill_and_full();
        logic [WORD_W-1:0] value;
        logic [POS_W-1:0]  pos;
        for (int n = 0; n < CAPACITY; n++) begin
            value = (n == 0) ? '0 : (n == 1) ? '1 : $urandom();
            pos   = (n % 3 == 0) ? '0 : (n % 3 == 1) ? POS_W'(n) : POS_W'(n / 2);
            apply_op(KIND_INSERT, pos, value);
        end
        apply_op(KIND_INSERT, POS_W'(CAPACITY), 32'h5555_5555);
        // index test wins over the full test
        apply_op(KIND_INSERT, POS_W'(CAPACITY + 1), 32'hAAAA_AAAA);
    endtask

    task automatic test_read_remove();
        apply_op(KIND_READ, 5'd0, '1);
        apply_op(KIND_READ, POS_W'(CAPACITY - 1), '0);
        apply_op(KIND_READ, POS_W'(CAPACITY), '0);
        apply_op(KIND_REMOVE, 5'd31, '0);
        apply_op(KIND_REMOVE, 5'd0, '0);
        apply_op(KIND_REMOVE, POS_W'(CAPACITY - 2), '0);
        apply_op(KIND_REMOVE, 5'd6, '0);
    endtask

    // Chunks lean towards insert or remove so the count sweeps empty to full
    task automatic test_random_traffic();
        int                lean;
        int                roll;
        int                n_fill;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] value;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                lean         = $urandom_range(0, 2);
                sender_idles = ((n / 60) % 3) != 0;
            end
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            n_fill = list_fill;
            roll   = $urandom_range(0, 99);
            if (roll < 2)
                kind = KIND_UNUSED;
            else if (roll < ((lean == 0) ? 65 : (lean == 1) ? 25 : 45))
                kind = KIND_INSERT;
            else if (roll < ((lean == 0) ? 85 : (lean == 1) ? 75 : 72))
                kind = KIND_REMOVE;
            else
                kind = KIND_READ;
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                if (kind == KIND_INSERT)
                    pos = POS_W'($urandom_range(0, n_fill));
                else
                    pos = POS_W'($urandom_range(0, (n_fill > 0) ? n_fill - 1 : 0));
            end else if (roll < 90) begin
                pos = POS_W'(n_fill);
            end else begin
                pos = POS_W'($urandom_range(0, 31));
            end
            roll  = $urandom_range(0, 19);
            value = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom();
            apply_op(kind, pos, value);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_fill_and_full();
        test_read_remove();
        test_random_traffic();
        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("covered %0d operations, %0d results: %0d ok, %0d bad index, %0d list full",
                 ops_accepted, results_seen, ok_count, range_count, full_count);
        $display("largest list length reached: %0d of %0d", max_fill_seen, CAPACITY);
        if (error_count == 0)
            $display("indexed_list_insert_remove_top: match");
        else
            $display("indexed_list_insert_remove_top: mismatch");
        $finish;
    end

endmodule
